// File: hw/rtl/adif_pkg.sv
// Package for the ADIF tag tokenizer: event codes, character constants,
// length width and small character helpers. No dependencies.
package adif_pkg;

    // Width of the internal length accumulator and byte counter
    localparam int LENGTH_BITS   = 16;
    localparam int FIELD_LEN_W   = 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Event codes on the result channel
    typedef enum logic [2:0] {
        EV_NAME_BYTE    = 3'd0,
        EV_TAG_CLOSED   = 3'd1,
        EV_CONTENT_BYTE = 3'd2,
        EV_HEADER_END   = 3'd3,
        EV_INPUT_OK     = 3'd4,
        EV_INPUT_TRUNC  = 3'd5,
        EV_NONE         = 3'd6
    } t_event;

    // Input item kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Keyword matcher: 0..3 = characters matched, MATCH_FAIL = mismatch
    localparam logic [2:0] MATCH_FULL = 3'd3;
    localparam logic [2:0] MATCH_FAIL = 3'd4;

    // ASCII upper-case, a-z only
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // One step of matching a three-letter keyword
    function automatic logic [2:0] match_step(input logic [2:0] m, input logic [7:0] c,
                                              input logic [7:0] k0, input logic [7:0] k1,
                                              input logic [7:0] k2);
        logic [2:0] r;
        r = MATCH_FAIL;
        case (m)
            3'd0: if (c == k0) r = 3'd1;
            3'd1: if (c == k1) r = 3'd2;
            3'd2: if (c == k2) r = 3'd3;
            default: r = MATCH_FAIL;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/adif_stream_if.sv
// Valid/ready channel interfaces for the ADIF tag tokenizer.
// Depends on adif_pkg.
interface adif_in_if import adif_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;

    modport source (output valid, kind, text_byte, input ready);
    modport sink   (input valid, kind, text_byte, output ready);
endinterface

interface adif_out_if import adif_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [2:0]             event_res;
    logic [7:0]             data_byte;
    logic [FIELD_LEN_W-1:0] field_length;
    logic                   is_record_end;
    logic                   field_done;
    logic                   header_seen;

    modport source (output valid, event_res, data_byte, field_length, is_record_end,
                    field_done, header_seen, input ready);
    modport sink   (input valid, event_res, data_byte, field_length, is_record_end,
                    field_done, header_seen, output ready);
endinterface

// File: hw/rtl/adif_tag_tokenizer.sv
// ADIF tag tokenizer top level: input register, tokenizer state, result register.
// Depends on adif_pkg and the channel interfaces in adif_stream_if.sv.
//
// Usage:
//   i_in carries one request per text byte (kind = 0) or an end-of-input
//   marker (kind = 1). o_out carries zero or one result per request: name
//   bytes, tag close with its declared length, content bytes, header end,
//   and the final ok / truncated report.
//   A request passes through the input register and then the result
//   register before its result appears on o_out. Throughput: one request
//   per cycle while o_out is not stalled; the tokenizer state updates
//   once per byte, so back-to-back bytes flow without gaps. When o_out is
//   stalled the result register holds, the input register still takes
//   one more request, and i_in.ready drops only when both are full. A
//   request that produces no result leaves the input register without
//   using the result register, unless o_out is stalled.
//   Reset (synchronous, i_rst_n low) returns to the start phase with all
//   counters and flags cleared and both registers empty. After end of input
//   has been reported every later request is consumed with no result.
module adif_tag_tokenizer import adif_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adif_in_if.sink     i_in,
    adif_out_if.source  o_out
);

    typedef enum logic [3:0] {
        PH_START, PH_HDR_TEXT, PH_HDR_TAG, PH_BETWEEN, PH_NAME,
        PH_LEN, PH_TYPE, PH_CONTENT, PH_DONE
    } t_phase;

    localparam int ACC_W = LENGTH_BITS + 4;

    // Input register
    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_byte;

    // Tokenizer state
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_eor_match, n_eor_match;
    logic [2:0]             r_eoh_match, n_eoh_match;
    logic [LENGTH_BITS-1:0] r_len_acc, n_len_acc;
    logic                   r_len_bad, n_len_bad;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                   r_rec_seen, n_rec_seen;
    logic                   r_hdr_flag, n_hdr_flag;

    // Result register
    logic                   r_out_valid;
    t_event                 r_ev;
    logic [7:0]             r_data;
    logic [FIELD_LEN_W-1:0] r_flen;
    logic                   r_rec;
    logic                   r_done;
    logic                   r_hdr;

    // Combinational result
    logic                   res_valid;
    t_event                 res_ev;
    logic [7:0]             res_data;
    logic [FIELD_LEN_W-1:0] res_flen;
    logic                   res_rec;
    logic                   res_done;

    logic advance, proc;
    logic [7:0]             uc;
    logic [LENGTH_BITS-1:0] close_len;
    logic                   close_rec;
    logic [ACC_W-1:0]       acc_next;
    logic [LENGTH_BITS-1:0] bl_dec;

    assign advance    = !r_out_valid || o_out.ready;
    assign proc       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign uc        = upcase(r_byte);
    assign close_len = r_len_bad ? '0 : r_len_acc;
    assign close_rec = (r_eor_match == MATCH_FULL);
    assign acc_next  = (ACC_W'(r_len_acc) << 3) + (ACC_W'(r_len_acc) << 1)
                     + ACC_W'(r_byte - CH_0);
    assign bl_dec    = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    // Per-byte state update and result
    always_comb begin
        n_phase      = r_phase;
        n_eor_match  = r_eor_match;
        n_eoh_match  = r_eoh_match;
        n_len_acc    = r_len_acc;
        n_len_bad    = r_len_bad;
        n_bytes_left = r_bytes_left;
        n_rec_seen   = r_rec_seen;
        n_hdr_flag   = r_hdr_flag;
        res_valid    = 1'b0;
        res_ev       = EV_NONE;
        res_data     = '0;
        res_flen     = '0;
        res_rec      = 1'b0;
        res_done     = 1'b0;

        if (proc && r_phase != PH_DONE) begin
            if (r_kind == KIND_END) begin
                res_valid = 1'b1;
                res_ev    = (r_phase == PH_BETWEEN && r_rec_seen) ? EV_INPUT_OK
                                                                  : EV_INPUT_TRUNC;
                n_phase   = PH_DONE;
            end else begin
                unique case (r_phase)
                    PH_START: begin
                        if (r_byte == CH_LT) begin
                            n_phase     = PH_NAME;
                            n_eor_match = '0;
                            n_len_acc   = '0;
                            n_len_bad   = 1'b0;
                        end else begin
                            n_phase = PH_HDR_TEXT;
                        end
                    end
                    PH_HDR_TEXT: begin
                        if (r_byte == CH_LT) begin
                            n_phase     = PH_HDR_TAG;
                            n_eoh_match = '0;
                        end
                    end
                    PH_HDR_TAG: begin
                        if (r_byte == CH_GT) begin
                            n_eoh_match = '0;
                            if (r_eoh_match == MATCH_FULL) begin
                                n_hdr_flag = 1'b1;
                                n_phase    = PH_BETWEEN;
                                res_valid  = 1'b1;
                                res_ev     = EV_HEADER_END;
                            end else begin
                                n_phase = PH_HDR_TEXT;
                            end
                        end else begin
                            n_eoh_match = match_step(r_eoh_match, uc, CH_E, CH_O, CH_H);
                        end
                    end
                    PH_BETWEEN: begin
                        if (r_byte == CH_LT) begin
                            n_phase     = PH_NAME;
                            n_eor_match = '0;
                            n_len_acc   = '0;
                            n_len_bad   = 1'b0;
                        end
                    end
                    PH_NAME, PH_LEN, PH_TYPE: begin
                        if (r_byte == CH_GT) begin
                            // tag close
                            res_valid = 1'b1;
                            res_ev    = EV_TAG_CLOSED;
                            res_flen  = FIELD_LEN_W'(32'(close_len));
                            res_rec   = close_rec;
                            if (close_len == '0) begin
                                res_done = 1'b1;
                                n_phase  = PH_BETWEEN;
                                if (close_rec) n_rec_seen = 1'b1;
                            end else begin
                                n_bytes_left = close_len;
                                n_phase      = PH_CONTENT;
                            end
                        end else if (r_phase == PH_TYPE) begin
                            n_phase = PH_TYPE;
                        end else if (r_byte == CH_COLON) begin
                            n_phase = (r_phase == PH_NAME) ? PH_LEN : PH_TYPE;
                        end else if (r_byte == CH_SPACE) begin
                            n_phase = r_phase;
                        end else if (r_phase == PH_NAME) begin
                            n_eor_match = match_step(r_eor_match, uc, CH_E, CH_O, CH_R);
                            res_valid   = 1'b1;
                            res_ev      = EV_NAME_BYTE;
                            res_data    = uc;
                        end else if (r_byte >= CH_0 && r_byte <= CH_9) begin
                            // decimal accumulate with saturation
                            if (acc_next > ACC_W'(LEN_MAX)) begin
                                n_len_acc = LEN_MAX;
                            end else begin
                                n_len_acc = acc_next[LENGTH_BITS-1:0];
                            end
                        end else begin
                            n_len_bad = 1'b1;
                        end
                    end
                    PH_CONTENT: begin
                        n_bytes_left = bl_dec;
                        res_valid    = 1'b1;
                        res_ev       = EV_CONTENT_BYTE;
                        res_data     = r_byte;
                        res_rec      = close_rec;
                        if (bl_dec == '0) begin
                            res_done = 1'b1;
                            n_phase  = PH_BETWEEN;
                            if (close_rec) n_rec_seen = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // State, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_START;
            r_eor_match  <= '0;
            r_eoh_match  <= '0;
            r_len_acc    <= '0;
            r_len_bad    <= 1'b0;
            r_bytes_left <= '0;
            r_rec_seen   <= 1'b0;
            r_hdr_flag   <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end
            r_phase      <= n_phase;
            r_eor_match  <= n_eor_match;
            r_eoh_match  <= n_eoh_match;
            r_len_acc    <= n_len_acc;
            r_len_bad    <= n_len_bad;
            r_bytes_left <= n_bytes_left;
            r_rec_seen   <= n_rec_seen;
            r_hdr_flag   <= n_hdr_flag;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.text_byte;
        end
        if (advance && res_valid) begin
            r_ev   <= res_ev;
            r_data <= res_data;
            r_flen <= res_flen;
            r_rec  <= res_rec;
            r_done <= res_done;
            r_hdr  <= n_hdr_flag;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_ev;
    assign o_out.data_byte     = r_data;
    assign o_out.field_length  = r_flen;
    assign o_out.is_record_end = r_rec;
    assign o_out.field_done    = r_done;
    assign o_out.header_seen   = r_hdr;

endmodule

// File: tb/adif_tag_tokenizer_tb.sv
// Testbench for adif_tag_tokenizer: drives ADIF text through the request channel,
// predicts every token and checks the result channel against it.
// Depends on adif_pkg, adif_stream_if.sv and the adif_tag_tokenizer RTL.
`timescale 1ns / 1ps

module adif_tag_tokenizer_tb;
    import adif_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 48;
    localparam int DRAIN_CYCLES = 16;

    // Tokenizer states as the predictor tracks them
    typedef enum logic [3:0] {
        ST_START, ST_HDR_TEXT, ST_HDR_TAG, ST_BETWEEN, ST_NAME,
        ST_LEN, ST_TYPE, ST_CONTENT, ST_DONE
    } tok_state_e;

    typedef struct packed {
        logic [2:0]             ev;
        logic [7:0]             data;
        logic [FIELD_LEN_W-1:0] flen;
        logic                   rec;
        logic                   done;
        logic                   hdr;
    } token_t;

    // Token predictor plus the queue of tokens still owed by the block
    class token_scoreboard;
        tok_state_e      st;
        logic [2:0]      eor_cnt;
        logic [2:0]      eoh_cnt;
        longint unsigned len_acc;
        longint unsigned remaining;
        bit              len_bad;
        bit              eor_seen;
        bit              hdr_flag;
        token_t          expected_tokens[$];
        int              errors;

        function new();
            st        = ST_START;
            eor_cnt   = '0;
            eoh_cnt   = '0;
            len_acc   = 0;
            remaining = 0;
            len_bad   = 1'b0;
            eor_seen  = 1'b0;
            hdr_flag  = 1'b0;
            errors    = 0;
        endfunction

        function logic [7:0] to_upper(input logic [7:0] c);
            if (c >= "a" && c <= "z") begin
                return c - 8'd32;
            end
            return c;
        endfunction

        function logic [2:0] next_match(input logic [2:0] m, input logic [7:0] c,
                                        input logic [7:0] k0, input logic [7:0] k1,
                                        input logic [7:0] k2);
            if (m == 3'd0 && c == k0) return 3'd1;
            if (m == 3'd1 && c == k1) return 3'd2;
            if (m == 3'd2 && c == k2) return MATCH_FULL;
            return MATCH_FAIL;
        endfunction

        function token_t pack_token(input logic [2:0] ev, input logic [7:0] d,
                                    input longint unsigned len, input bit rec, input bit done);
            token_t t;
            t.ev   = ev;
            t.data = d;
            t.flen = len[FIELD_LEN_W-1:0];
            t.rec  = rec;
            t.done = done;
            t.hdr  = hdr_flag;
            return t;
        endfunction

        function void open_tag();
            st      = ST_NAME;
            eor_cnt = '0;
            len_acc = 0;
            len_bad = 1'b0;
        endfunction

        function token_t close_tag();
            longint unsigned len;
            bit rec;
            len = len_bad ? 0 : len_acc;
            rec = (eor_cnt == MATCH_FULL);
            if (len == 0) begin
                if (rec) eor_seen = 1'b1;
                st = ST_BETWEEN;
                return pack_token(EV_TAG_CLOSED, 8'h00, len, rec, 1'b1);
            end
            remaining = len;
            st = ST_CONTENT;
            return pack_token(EV_TAG_CLOSED, 8'h00, len, rec, 1'b0);
        endfunction

        // One byte or end marker in; returns 1 when it yields a token
        function bit tokenize(input logic k, input logic [7:0] b, output token_t t);
            logic [7:0] c;
            longint unsigned nxt;
            bit rec;
            bit done;
            t = '0;
            c = b;
            if (st == ST_DONE) return 0;
            if (k == KIND_END) begin
                t = pack_token((st == ST_BETWEEN && eor_seen) ? EV_INPUT_OK : EV_INPUT_TRUNC,
                               8'h00, 0, 1'b0, 1'b0);
                st = ST_DONE;
                return 1;
            end
            case (st)
                ST_START: begin
                    if (c == CH_LT) open_tag();
                    else st = ST_HDR_TEXT;
                    return 0;
                end
                ST_HDR_TEXT: begin
                    if (c == CH_LT) begin
                        st      = ST_HDR_TAG;
                        eoh_cnt = '0;
                    end
                    return 0;
                end
                ST_HDR_TAG: begin
                    if (c == CH_GT) begin
                        if (eoh_cnt == MATCH_FULL) begin
                            hdr_flag = 1'b1;
                            st       = ST_BETWEEN;
                            eoh_cnt  = '0;
                            t = pack_token(EV_HEADER_END, 8'h00, 0, 1'b0, 1'b0);
                            return 1;
                        end
                        eoh_cnt = '0;
                        st      = ST_HDR_TEXT;
                        return 0;
                    end
                    eoh_cnt = next_match(eoh_cnt, to_upper(c), CH_E, CH_O, CH_H);
                    return 0;
                end
                ST_BETWEEN: begin
                    if (c == CH_LT) open_tag();
                    return 0;
                end
                ST_NAME: begin
                    if (c == CH_COLON) begin
                        st = ST_LEN;
                        return 0;
                    end
                    if (c == CH_GT) begin
                        t = close_tag();
                        return 1;
                    end
                    if (c == CH_SPACE) return 0;
                    c = to_upper(c);
                    eor_cnt = next_match(eor_cnt, c, CH_E, CH_O, CH_R);
                    t = pack_token(EV_NAME_BYTE, c, 0, 1'b0, 1'b0);
                    return 1;
                end
                ST_LEN: begin
                    if (c == CH_COLON) begin
                        st = ST_TYPE;
                        return 0;
                    end
                    if (c == CH_GT) begin
                        t = close_tag();
                        return 1;
                    end
                    if (c == CH_SPACE) return 0;
                    if (c >= CH_0 && c <= CH_9) begin
                        // saturate instead of wrapping
                        nxt = len_acc * 10 + (c - CH_0);
                        len_acc = (nxt > LEN_MAX) ? LEN_MAX : nxt;
                    end else begin
                        len_bad = 1'b1;
                    end
                    return 0;
                end
                ST_TYPE: begin
                    if (c == CH_GT) begin
                        t = close_tag();
                        return 1;
                    end
                    return 0;
                end
                ST_CONTENT: begin
                    rec  = (eor_cnt == MATCH_FULL);
                    done = 1'b0;
                    if (remaining > 0) remaining--;
                    if (remaining == 0) begin
                        done = 1'b1;
                        if (rec) eor_seen = 1'b1;
                        st = ST_BETWEEN;
                    end
                    t = pack_token(EV_CONTENT_BYTE, c, 0, rec, done);
                    return 1;
                end
                default: begin
                    st = ST_DONE;
                    return 0;
                end
            endcase
        endfunction

        function void note_request(input logic k, input logic [7:0] b);
            token_t t;
            if (tokenize(k, b, t)) expected_tokens.push_back(t);
        endfunction

        function void check_result(input token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected result ev=%0d data=%02h len=%0d rec=%b done=%b hdr=%b",
                         $time, got.ev, got.data, got.flen, got.rec, got.done, got.hdr);
                return;
            end
            want = expected_tokens.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected ev=%0d data=%02h len=%0d rec=%b done=%b hdr=%b",
                         $time, want.ev, want.data, want.flen, want.rec, want.done, want.hdr);
                $display("%0t:          actual   ev=%0d data=%02h len=%0d rec=%b done=%b hdr=%b",
                         $time, got.ev, got.data, got.flen, got.rec, got.done, got.hdr);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    adif_in_if  in_if ();
    adif_out_if out_if ();

    adif_tag_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    token_scoreboard tok_sb     = new();
    token_scoreboard stim_track = new();

    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   sent          = 0;
    int   cycle_count   = 0;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL adif_tag_tokenizer");
            $finish;
        end
    end

    // Result side backpressure, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitors: requests feed the predictor, results are checked against it
    always @(posedge i_clk) begin : mon
        token_t got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) tok_sb.note_request(in_if.kind, in_if.text_byte);
            if (out_if.valid && out_if.ready) begin
                got.ev   = out_if.event_res;
                got.data = out_if.data_byte;
                got.flen = out_if.field_length;
                got.rec  = out_if.is_record_end;
                got.done = out_if.field_done;
                got.hdr  = out_if.header_seen;
                tok_sb.check_result(got);
            end
        end
    end

    // Offer one request and wait until it is taken
    task automatic put(input logic k, input logic [7:0] b);
        token_t dummy;
        void'(stim_track.tokenize(k, b, dummy));
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= k;
        in_if.text_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(KIND_TEXT, s[i]);
    endtask

    // Finish whatever content the last tag declared
    task automatic fill_content();
        while (stim_track.st == ST_CONTENT) put(KIND_TEXT, 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        if ($urandom_range(9) < 7) begin
            c = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h61 : 8'h41);
        end else begin
            do c = 8'($urandom_range(255)); while (c == CH_COLON || c == CH_GT);
        end
        return c;
    endfunction

    // Non-digit that spoils a length field
    function automatic logic [7:0] pick_bad_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while ((c >= CH_0 && c <= CH_9) || c == CH_COLON || c == CH_GT || c == CH_SPACE);
        return c;
    endfunction

    // Tag with random name, length form (sometimes spoiled by a non-digit), type and content
    task automatic rand_tag();
        int    sel;
        int    v;
        string num;
        logic [7:0] c;
        put(KIND_TEXT, CH_LT);
        if ($urandom_range(9) == 0) begin
            put_text($urandom_range(1) ? "eor" : "EoR");
        end else begin
            repeat ($urandom_range(1, 6)) put(KIND_TEXT, pick_name_char());
        end
        sel = $urandom_range(99);
        if (sel >= 15) begin
            put(KIND_TEXT, CH_COLON);
            if (sel >= 20) begin
                v = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                if ($urandom_range(4) == 0) num = $sformatf("%03d", v);
                else num = $sformatf("%0d", v);
                for (int i = 0; i < num.len(); i++) begin
                    put(KIND_TEXT, num[i]);
                    if ($urandom_range(9) == 0) put(KIND_TEXT, CH_SPACE);
                end
                if (sel >= 90) put(KIND_TEXT, pick_bad_digit());
            end
            if ($urandom_range(2) == 0) begin
                put(KIND_TEXT, CH_COLON);
                do c = 8'($urandom_range(255)); while (c == CH_GT);
                put(KIND_TEXT, c);
            end
        end
        put(KIND_TEXT, CH_GT);
        fill_content();
    endtask

    // Random bytes, then steer back to the gap between tags
    task automatic noise_burst();
        repeat ($urandom_range(1, 6)) put(KIND_TEXT, 8'($urandom_range(255)));
        while (stim_track.st != ST_BETWEEN) begin
            if (stim_track.st == ST_CONTENT) put(KIND_TEXT, 8'($urandom_range(255)));
            else put(KIND_TEXT, CH_GT);
        end
    endtask

    task automatic gap_text();
        logic [7:0] c;
        repeat ($urandom_range(0, 3)) begin
            do c = 8'($urandom_range(255)); while (c == CH_LT);
            put(KIND_TEXT, c);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input bit pressure);
        int first;
        int next_hold;
        first         = sent;
        next_hold     = 40;
        src_idle_pct  = idle_pct;
        snk_stall_pct <= stall_pct;
        while (sent - first < count) begin
            if (pressure && sent - first >= next_hold) begin
                hold_req  <= ~hold_req;
                next_hold += 90;
            end
            if ($urandom_range(9) == 0) noise_burst();
            else rand_tag();
            gap_text();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.kind      <= KIND_TEXT;
        in_if.text_byte <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header with leading blank, near-miss tags, then a mixed-case EOH
        put_text(" ADIF log\r\n<adif_ver:5>3.1.0<e oh><EOHX><eo><eOh>\r\n");
        // Content ending in an open bracket, then ignored text between tags
        put_text("<CALL:4>k1a<x <Name:0>");
        // Empty and missing length, typed field, signed and junk lengths
        put_text("<a:><b><Freq:3:N>14.<qth:-2><rst:5x>");
        // Length with embedded blanks; content covers byte extremes
        put_text("<g: 1 2:S>");
        put(KIND_TEXT, 8'h00);
        put(KIND_TEXT, 8'hFF);
        put(KIND_TEXT, 8'h80);
        put(KIND_TEXT, 8'h7F);
        put(KIND_TEXT, 8'h55);
        put(KIND_TEXT, 8'hAA);
        put(KIND_TEXT, 8'h01);
        put(KIND_TEXT, 8'hFE);
        put(KIND_TEXT, CH_LT);
        put(KIND_TEXT, CH_GT);
        put(KIND_TEXT, CH_COLON);
        put(KIND_TEXT, CH_SPACE);
        fill_content();
        // Record end spelled with blanks
        put_text("< e o r >");
        // Name bytes around the a-z range and above ASCII
        put(KIND_TEXT, CH_LT);
        put(KIND_TEXT, 8'h60);
        put_text("az");
        put(KIND_TEXT, 8'h7B);
        put_text("@[");
        put(KIND_TEXT, 8'hE9);
        put(KIND_TEXT, 8'hFF);
        put(KIND_TEXT, 8'h00);
        put(KIND_TEXT, 8'h80);
        put(KIND_TEXT, CH_LT);
        put_text(":1>Q<eor:2>zz");

        run_phase(0, 0, 200, 1'b1);
        run_phase(55, 0, 200, 1'b0);
        run_phase(0, 55, 200, 1'b0);
        run_phase(17, 17, 200, 1'b0);

        // One end of input per run: either clean or cut short
        src_idle_pct  = 0;
        snk_stall_pct <= 0;
        case ($urandom_range(2))
            0: put(KIND_END, 8'($urandom_range(255)));
            1: begin
                // saturated length, cut short inside its content
                put_text("<big:0065536>xy");
                put(KIND_END, 8'h00);
            end
            default: begin
                put_text("<q");
                put(KIND_END, 8'hFF);
            end
        endcase
        // Everything after the end marker is swallowed
        put_text("<eor>");
        put(KIND_END, 8'h5A);
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (tok_sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tok_sb.errors == 0) begin
            $display("PASS adif_tag_tokenizer");
        end else begin
            $display("FAIL adif_tag_tokenizer");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/adif_pkg.sv
hw/rtl/adif_stream_if.sv
hw/rtl/adif_tag_tokenizer.sv
tb/adif_tag_tokenizer_tb.sv
